FILE: rtl/core/task_lifecycle_sync_fsm_unit_defines.svh
// Assertion macros used by the core RTL (tlsf_core) of the task lifecycle unit.
`ifndef TASK_LIFECYCLE_SYNC_FSM_UNIT_DEFINES_SVH
`define TASK_LIFECYCLE_SYNC_FSM_UNIT_DEFINES_SVH

`ifndef SYNTH

`define TLSF_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("tlsf assertion failed");

`define TLSF_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("tlsf assertion failed");

`else

`define TLSF_ASSERT_NOW(name, pre, post)

`define TLSF_ASSERT_NEXT(name, pre, post)

`endif

`endif

FILE: rtl/core/tlsf_pkg.sv
`default_nettype none

package tlsf_pkg;

    localparam int MODE_ID_BITS = 16;
    localparam int CLUSTER_BITS = 16;

    typedef enum logic [2:0] {
        ACT_ENABLE    = 3'd0,
        ACT_DISABLE   = 3'd1,
        ACT_TERMINATE = 3'd2,
        ACT_SCHEDULE  = 3'd3,
        ACT_COMMIT    = 3'd4,
        ACT_CONTINUE  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        RUN_DISABLED = 3'd0,
        RUN_READY    = 3'd1,
        RUN_SYNC     = 3'd2,
        RUN_RUNNING  = 3'd3,
        RUN_FINISHED = 3'd4
    } t_run;

    typedef enum logic [2:0] {
        SYNC_STARTING = 3'd0,
        SYNC_RECONF   = 3'd1,
        SYNC_MIGREC   = 3'd2,
        SYNC_MIGRATE  = 3'd3,
        SYNC_BLOCKED  = 3'd4,
        SYNC_IDLE     = 3'd5
    } t_sync;

    typedef enum logic [2:0] {
        ST_SUCCESS  = 3'd0,
        ST_ABORT    = 3'd1,
        ST_DISABLED = 3'd2,
        ST_REJECTED = 3'd3,
        ST_ACCEPTED = 3'd4
    } t_status;

    typedef struct packed {
        t_action                  action;
        logic [MODE_ID_BITS-1:0]  mode_id;
        logic [CLUSTER_BITS-1:0]  cluster_mask;
        logic                     clusters_moved;
        logic                     booking_ok;
    } t_in;

    typedef struct packed {
        t_status                  status;
        t_run                     run_state_out;
        t_sync                    sync_state_out;
        t_run                     pre_sync_state_out;
        logic                     current_valid;
        logic [MODE_ID_BITS-1:0]  current_mode_out;
        logic                     release_request;
    } t_out;

    typedef struct packed {
        logic valid;
        t_in  item;
    } t_in_slot;

endpackage

`default_nettype wire

FILE: rtl/core/tlsf_in_stage.sv
`default_nettype none

module tlsf_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire tlsf_pkg::t_in  i_in,
    output logic                o_stall,
    input  wire logic           i_fire,
    output tlsf_pkg::t_in_slot  o_slot
);

    logic          r_valid;
    tlsf_pkg::t_in r_item;
    logic          accept;

    assign o_stall = r_valid && !i_fire;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.item  = r_item;

endmodule

`default_nettype wire

FILE: rtl/core/tlsf_core.sv
`default_nettype none

module tlsf_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire tlsf_pkg::t_in i_item,
    output tlsf_pkg::t_out     o_result
);

    `include "task_lifecycle_sync_fsm_unit_defines.svh"

    typedef struct packed {
        tlsf_pkg::t_run  run;
        tlsf_pkg::t_run  pre;
        tlsf_pkg::t_sync sync;
        logic            cur_valid;
    } t_ctx;

    function automatic t_ctx f_stable(input t_ctx c, input tlsf_pkg::t_run s);
        t_ctx r;
        r      = c;
        r.run  = s;
        r.pre  = s;
        r.sync = tlsf_pkg::SYNC_IDLE;
        if (s == tlsf_pkg::RUN_DISABLED || s == tlsf_pkg::RUN_READY) begin
            r.cur_valid = 1'b0;
        end
        return r;
    endfunction

    function automatic t_ctx f_enter_sync(input t_ctx c, input tlsf_pkg::t_sync ss);
        t_ctx r;
        r      = c;
        r.pre  = c.run;
        r.sync = ss;
        r.run  = tlsf_pkg::RUN_SYNC;
        return r;
    endfunction

    function automatic logic f_off(input tlsf_pkg::t_run s);
        return s == tlsf_pkg::RUN_DISABLED || s == tlsf_pkg::RUN_FINISHED;
    endfunction

    t_ctx                                r_ctx;
    t_ctx                                n_ctx;
    logic [tlsf_pkg::MODE_ID_BITS-1:0]   r_cur_mode;
    logic [tlsf_pkg::MODE_ID_BITS-1:0]   n_cur_mode;
    logic [tlsf_pkg::CLUSTER_BITS-1:0]   r_cur_clusters;
    logic [tlsf_pkg::CLUSTER_BITS-1:0]   n_cur_clusters;
    logic                                r_next_valid;
    logic                                n_next_valid;
    logic [tlsf_pkg::MODE_ID_BITS-1:0]   r_next_mode;
    logic [tlsf_pkg::MODE_ID_BITS-1:0]   n_next_mode;
    logic [tlsf_pkg::CLUSTER_BITS-1:0]   r_next_clusters;
    logic [tlsf_pkg::CLUSTER_BITS-1:0]   n_next_clusters;

    t_ctx                                unblocked;
    tlsf_pkg::t_sync                     need;
    tlsf_pkg::t_status                   status;
    logic                                release_req;
    logic                                mode_same;
    logic                                clus_same;

    assign mode_same = (r_cur_mode == i_item.mode_id);
    assign clus_same = (r_cur_clusters == i_item.cluster_mask);

    always_comb begin
        if (!r_ctx.cur_valid) begin
            need = tlsf_pkg::SYNC_RECONF;
        end else if (!mode_same && !clus_same) begin
            need = tlsf_pkg::SYNC_MIGREC;
        end else if (mode_same && i_item.clusters_moved) begin
            need = tlsf_pkg::SYNC_MIGRATE;
        end else if (!mode_same) begin
            need = tlsf_pkg::SYNC_RECONF;
        end else begin
            need = tlsf_pkg::SYNC_IDLE;
        end
    end

    always_comb begin
        unblocked = r_ctx;
        if (r_ctx.run == tlsf_pkg::RUN_SYNC && r_ctx.sync == tlsf_pkg::SYNC_BLOCKED) begin
            unblocked = f_stable(r_ctx, r_ctx.pre);
        end
    end

    always_comb begin
        n_ctx           = r_ctx;
        n_cur_mode      = r_cur_mode;
        n_cur_clusters  = r_cur_clusters;
        n_next_valid    = r_next_valid;
        n_next_mode     = r_next_mode;
        n_next_clusters = r_next_clusters;
        status          = tlsf_pkg::ST_ABORT;
        release_req     = 1'b0;
        case (i_item.action)
            tlsf_pkg::ACT_ENABLE: begin
                if (f_off(r_ctx.run)) begin
                    n_ctx  = f_stable(r_ctx, tlsf_pkg::RUN_READY);
                    status = tlsf_pkg::ST_SUCCESS;
                end
            end
            tlsf_pkg::ACT_DISABLE: begin
                if (!f_off(r_ctx.run)) begin
                    release_req = r_ctx.cur_valid;
                    n_ctx       = f_stable(r_ctx, tlsf_pkg::RUN_DISABLED);
                end
                status = tlsf_pkg::ST_SUCCESS;
            end
            tlsf_pkg::ACT_TERMINATE: begin
                release_req = r_ctx.cur_valid;
                n_ctx       = f_stable(r_ctx, tlsf_pkg::RUN_FINISHED);
                status      = tlsf_pkg::ST_SUCCESS;
            end
            tlsf_pkg::ACT_SCHEDULE: begin
                n_ctx = unblocked;
                if (f_off(unblocked.run)) begin
                    status = tlsf_pkg::ST_DISABLED;
                end else if (!i_item.booking_ok) begin
                    if (unblocked.run == tlsf_pkg::RUN_RUNNING) begin
                        n_ctx = f_enter_sync(unblocked, tlsf_pkg::SYNC_BLOCKED);
                    end
                    status = tlsf_pkg::ST_REJECTED;
                end else if (unblocked.run == tlsf_pkg::RUN_READY ||
                             unblocked.run == tlsf_pkg::RUN_RUNNING) begin
                    if (unblocked.run == tlsf_pkg::RUN_READY) begin
                        n_ctx = f_enter_sync(unblocked, tlsf_pkg::SYNC_STARTING);
                    end else if (need != tlsf_pkg::SYNC_IDLE) begin
                        n_ctx = f_enter_sync(unblocked, need);
                    end
                    n_next_valid    = 1'b1;
                    n_next_mode     = i_item.mode_id;
                    n_next_clusters = i_item.cluster_mask;
                    status          = tlsf_pkg::ST_ACCEPTED;
                end else begin
                    release_req = 1'b1;
                    status      = tlsf_pkg::ST_REJECTED;
                end
            end
            tlsf_pkg::ACT_COMMIT: begin
                if (f_off(r_ctx.run)) begin
                    status = tlsf_pkg::ST_SUCCESS;
                end else if (r_ctx.sync == tlsf_pkg::SYNC_STARTING ||
                             r_ctx.sync == tlsf_pkg::SYNC_RECONF ||
                             r_ctx.sync == tlsf_pkg::SYNC_MIGREC ||
                             r_ctx.sync == tlsf_pkg::SYNC_MIGRATE) begin
                    n_ctx           = r_ctx;
                    n_ctx.cur_valid = r_next_valid;
                    n_ctx           = f_stable(n_ctx, tlsf_pkg::RUN_RUNNING);
                    n_cur_mode      = r_next_mode;
                    n_cur_clusters  = r_next_clusters;
                    n_next_valid    = 1'b0;
                    status          = tlsf_pkg::ST_SUCCESS;
                end else if (r_ctx.sync == tlsf_pkg::SYNC_BLOCKED) begin
                    n_ctx        = f_stable(r_ctx, tlsf_pkg::RUN_READY);
                    n_next_valid = 1'b0;
                    status       = tlsf_pkg::ST_SUCCESS;
                end
            end
            tlsf_pkg::ACT_CONTINUE: begin
                if (r_ctx.cur_valid && r_next_valid && r_ctx.run == tlsf_pkg::RUN_RUNNING &&
                    r_cur_mode == r_next_mode) begin
                    n_next_valid = 1'b0;
                    status       = tlsf_pkg::ST_SUCCESS;
                end
            end
            default: begin
                status = tlsf_pkg::ST_ABORT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.run       <= tlsf_pkg::RUN_DISABLED;
            r_ctx.pre       <= tlsf_pkg::RUN_DISABLED;
            r_ctx.sync      <= tlsf_pkg::SYNC_IDLE;
            r_ctx.cur_valid <= 1'b0;
            r_cur_mode      <= '0;
            r_cur_clusters  <= '0;
            r_next_valid    <= 1'b0;
            r_next_mode     <= '0;
            r_next_clusters <= '0;
        end else if (i_fire) begin
            r_ctx           <= n_ctx;
            r_cur_mode      <= n_cur_mode;
            r_cur_clusters  <= n_cur_clusters;
            r_next_valid    <= n_next_valid;
            r_next_mode     <= n_next_mode;
            r_next_clusters <= n_next_clusters;
        end
    end

    assign o_result.status             = status;
    assign o_result.run_state_out      = n_ctx.run;
    assign o_result.sync_state_out     = n_ctx.sync;
    assign o_result.pre_sync_state_out = n_ctx.pre;
    assign o_result.current_valid      = n_ctx.cur_valid;
    assign o_result.current_mode_out   = n_ctx.cur_valid ? n_cur_mode : '0;
    assign o_result.release_request    = release_req;

    `TLSF_ASSERT_NOW(a_sync_iff_run_sync, 1'b1,
        (r_ctx.run == tlsf_pkg::RUN_SYNC) == (r_ctx.sync != tlsf_pkg::SYNC_IDLE))
    `TLSF_ASSERT_NOW(a_pre_tracks_stable, r_ctx.run != tlsf_pkg::RUN_SYNC,
        r_ctx.pre == r_ctx.run)
    `TLSF_ASSERT_NEXT(a_commit_runs, i_fire && i_item.action == tlsf_pkg::ACT_COMMIT &&
        r_ctx.run == tlsf_pkg::RUN_SYNC && r_ctx.sync != tlsf_pkg::SYNC_BLOCKED,
        r_ctx.run == tlsf_pkg::RUN_RUNNING && !r_next_valid)
    `TLSF_ASSERT_NEXT(a_hold_without_fire, !i_fire,
        $stable(r_ctx) && $stable(r_next_valid) && $stable(r_cur_mode))

endmodule

`default_nettype wire

FILE: rtl/core/task_lifecycle_sync_fsm_unit.sv
// Task lifecycle and synchronization state machine.
// Input channel: i_valid / o_stall with payload i_in (one event: action, offered
// mode id and cluster mask, clusters-moved flag, booking result). A transfer
// happens at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with payload o_out (status, run, sync and
// pre-sync states, current mode, release request), one result per event, in order.
// Path: an accepted event is held in the input register, processed against the
// task state when it fires, and its result is registered in the result register
// and driven on o_out.
// Throughput: one event per cycle while the receiver does not stall, set by the
// state update between the input register and the result register.
// Reset (i_rst_n low at a clock edge): both registers empty, task disabled,
// sync state none, no current or pending mode.
// When the receiver stalls, the result register holds; the input register still
// takes one more event, and o_stall rises once both are full.
`default_nettype none

module task_lifecycle_sync_fsm_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tlsf_pkg::t_in i_in,
    output logic               o_stall,
    output logic               o_valid,
    output tlsf_pkg::t_out     o_out,
    input  wire logic          i_stall
);

    tlsf_pkg::t_in_slot slot;
    tlsf_pkg::t_out     result;
    logic               out_free;
    logic               fire;
    logic               r_out_valid;
    tlsf_pkg::t_out     r_out;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = slot.valid && out_free;

    tlsf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .i_fire  (fire),
        .o_slot  (slot)
    );

    tlsf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (slot.item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire
